FILE: sv/lcg_pkg.sv
package lcg_pkg;

  localparam int SINE_ADDR_BITS = 10;
  localparam int COUNT_BITS     = 24;

  localparam int SINE_SIZE  = 1 << SINE_ADDR_BITS;
  localparam int SINE_W     = 17;
  localparam int PHASE_W    = 48;
  localparam int PHASE_TOP_W = SINE_ADDR_BITS + 2;
  localparam int INC_W      = 50;
  localparam int AMP_W      = 32;
  localparam int AMP_ACC_W  = 33;
  localparam int FREQ_W     = 48;
  localparam int SNR_W      = 16;
  localparam int SCOUNT_W   = 25;
  localparam int VALUE_W    = 24;
  localparam int IDX_W      = 24;
  localparam int EFF_W      = (COUNT_BITS + 1 > SCOUNT_W) ? COUNT_BITS + 1 : SCOUNT_W;

  localparam int PROD1_W     = AMP_ACC_W + SINE_W;
  localparam int PROD2_W     = PROD1_W + SNR_W;
  localparam int ROUND_SHIFT = 36;
  localparam int MAG_W       = PROD2_W - ROUND_SHIFT;
  localparam int VALUE_MAX   = (1 << (VALUE_W - 1)) - 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

  localparam logic [63:0] PIO2_Q30 = 64'h0000_0000_6487_ED51;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_AMPLITUDE = 3'd0,
    CFG_AMPLITUDE_STEP  = 3'd1,
    CFG_BASE_FREQ       = 3'd2,
    CFG_FREQUENCY_STEP  = 3'd3,
    CFG_SNR_GAIN        = 3'd4,
    CFG_SAMPLE_COUNT    = 3'd5,
    CFG_MUTE            = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [AMP_W-1:0]    start_amplitude;
    logic [AMP_W-1:0]    amplitude_step;
    logic [FREQ_W-1:0]   base_freq;
    logic [FREQ_W-1:0]   frequency_step;
    logic [SNR_W-1:0]    snr_gain;
    logic [SCOUNT_W-1:0] sample_count;
    logic                mute;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_TOP_W-1:0] phase_top;
    logic [AMP_ACC_W-1:0]   amp;
    logic [COUNT_BITS-1:0]  cnt;
    logic                   last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic accept;
    logic last;
    logic cnt_zero;
  } front_status_t;

  typedef logic [SINE_W-1:0] sine_tab_t [SINE_SIZE];

  // Quarter-wave sine magnitudes in Q1.16, sampled at the middle of each step.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] t;
    int unsigned a;
    int unsigned n;
    for (a = 0; a < SINE_SIZE; a++) begin
      x = (PIO2_Q30 * 64'(2 * a + 1)) >> (SINE_ADDR_BITS + 1);
      s = x;
      t = x;
      for (n = 1; n <= 10; n++) begin
        t = (((t * x) >> 30) * x) >> 30;
        t = t / 64'((2 * n) * (2 * n + 1));
        if (n[0]) begin
          s = s - t;
        end else begin
          s = s + t;
        end
      end
      tab[a] = SINE_W'((s + 64'd8192) >> 14);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: sv/linear_chirp_generator_top.sv
// Linear chirp generator: one sample per accepted transfer, one transfer per cycle sustained
// while the queue has room (in_stall_o low); results leave the last pipeline register.
// The front accumulators advance once per transfer; the back runs a four-stage
// table-read, two-multiply and round pipeline behind a four-entry queue.
// Reset clears the sample counter, the queue and the pipeline valid flags and
// loads the configuration registers with their defaults; the first transfer starts a run.
module linear_chirp_generator_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lcg_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [lcg_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   restart_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [lcg_pkg::VALUE_W-1:0]     sample_value_o,
  output logic [lcg_pkg::IDX_W-1:0]              sample_index_o,
  output logic                                   run_end_o
);
  import lcg_pkg::*;

  cfg_t          cfg_q;
  q_entry_t      push_entry;
  q_entry_t      pop_entry;
  q_status_t     q_status;
  front_status_t front_status;
  logic          push;
  logic          pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_amplitude <= AMP_W'(32'd16777216);
      cfg_q.amplitude_step  <= '0;
      cfg_q.base_freq       <= '0;
      cfg_q.frequency_step  <= '0;
      cfg_q.snr_gain        <= SNR_W'(16'd256);
      cfg_q.sample_count    <= SCOUNT_W'(1);
      cfg_q.mute            <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_START_AMPLITUDE: cfg_q.start_amplitude <= cfg_data_i[AMP_W-1:0];
        CFG_AMPLITUDE_STEP:  cfg_q.amplitude_step  <= cfg_data_i[AMP_W-1:0];
        CFG_BASE_FREQ:       cfg_q.base_freq       <= cfg_data_i[FREQ_W-1:0];
        CFG_FREQUENCY_STEP:  cfg_q.frequency_step  <= cfg_data_i[FREQ_W-1:0];
        CFG_SNR_GAIN:        cfg_q.snr_gain        <= cfg_data_i[SNR_W-1:0];
        CFG_SAMPLE_COUNT:    cfg_q.sample_count    <= cfg_data_i[SCOUNT_W-1:0];
        CFG_MUTE:            cfg_q.mute            <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  lcg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart_i),
    .q_full_i   (q_status.full),
    .push_o     (push),
    .entry_o    (push_entry),
    .status_o   (front_status)
  );

  lcg_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (pop_entry),
    .status_o (q_status)
  );

  lcg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .entry_i        (pop_entry),
    .empty_i        (q_status.empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_value_o (sample_value_o),
    .sample_index_o (sample_index_o),
    .run_end_o      (run_end_o)
  );

  // The last sample of a run always leaves the counter at zero for a reload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_status.accept && front_status.last |=> front_status.cnt_zero)
    else $error("counter not cleared after the last sample of a run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cfg_q.mute |-> sample_value_o == '0)
    else $error("nonzero sample in muted mode");

  // A run shortened in mid-flight ends on the first sample at or past the new count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_end_o && cfg_q.sample_count != '0 &&
    cfg_q.sample_count <= (SCOUNT_W'(1) << IDX_W)
    |-> SCOUNT_W'(sample_index_o) + SCOUNT_W'(1) >= cfg_q.sample_count)
    else $error("run end flagged on the wrong sample index");

endmodule

FILE: sv/lcg_front.sv
module lcg_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lcg_pkg::cfg_t            cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     restart_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output lcg_pkg::q_entry_t        entry_o,
  output lcg_pkg::front_status_t   status_o
);
  import lcg_pkg::*;

  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic [INC_W-1:0]      inc_q, inc_d;
  logic [AMP_ACC_W-1:0]  amp_q, amp_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  logic                  accept;
  logic                  load;
  logic [INC_W-1:0]      freq_step_ext;
  logic [PHASE_W-1:0]    cur_phase;
  logic [INC_W-1:0]      cur_inc;
  logic [AMP_ACC_W-1:0]  cur_amp;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [EFF_W-1:0]      count_ext;
  logic [EFF_W-1:0]      eff_count;
  logic [EFF_W-1:0]      cnt_next;
  logic                  last;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign load       = restart_i || (cnt_q == '0);

  assign freq_step_ext = {{(INC_W - FREQ_W){cfg_i.frequency_step[FREQ_W-1]}},
                          cfg_i.frequency_step};

  assign cur_phase = load ? '0 : phase_q;
  assign cur_inc   = load ? (INC_W'(cfg_i.base_freq) + freq_step_ext) : inc_q;
  assign cur_amp   = load ? AMP_ACC_W'(cfg_i.start_amplitude) : amp_q;
  assign cur_cnt   = load ? '0 : cnt_q;

  always_comb begin
    count_ext = EFF_W'(cfg_i.sample_count);
    if (count_ext == '0) begin
      eff_count = EFF_W'(1);
    end else if (count_ext > (EFF_W'(1) << COUNT_BITS)) begin
      eff_count = EFF_W'(1) << COUNT_BITS;
    end else begin
      eff_count = count_ext;
    end
  end

  assign cnt_next = EFF_W'(cur_cnt) + EFF_W'(1);
  assign last     = cnt_next >= eff_count;

  assign cnt_d   = last ? '0 : cnt_next[COUNT_BITS-1:0];
  assign phase_d = cur_phase + cur_inc[PHASE_W-1:0];
  assign inc_d   = cur_inc + (freq_step_ext << 1);
  assign amp_d   = cur_amp + {cfg_i.amplitude_step[AMP_W-1], cfg_i.amplitude_step};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      phase_q <= phase_d;
      inc_q   <= inc_d;
      amp_q   <= amp_d;
    end
  end

  assign push_o            = accept;
  assign entry_o.phase_top = cur_phase[PHASE_W-1 -: PHASE_TOP_W];
  assign entry_o.amp       = cur_amp;
  assign entry_o.cnt       = cur_cnt;
  assign entry_o.last      = last;

  assign status_o.accept   = accept;
  assign status_o.last     = last;
  assign status_o.cnt_zero = (cnt_q == '0);

endmodule

FILE: sv/lcg_queue.sv
module lcg_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lcg_pkg::q_entry_t   entry_i,
  input  logic                pop_i,
  output lcg_pkg::q_entry_t   entry_o,
  output lcg_pkg::q_status_t  status_o
);
  import lcg_pkg::*;

  q_entry_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_push;
  logic                   do_pop;

  assign status_o.full  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  assign wr_ptr_d = do_push ? wr_ptr_q + QUEUE_PTR_W'(1) : wr_ptr_q;
  assign rd_ptr_d = do_pop ? rd_ptr_q + QUEUE_PTR_W'(1) : rd_ptr_q;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o = mem_q[rd_ptr_q];

endmodule

FILE: sv/lcg_back.sv
module lcg_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lcg_pkg::cfg_t                        cfg_i,
  input  lcg_pkg::q_entry_t                    entry_i,
  input  logic                                 empty_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [lcg_pkg::VALUE_W-1:0]   sample_value_o,
  output logic [lcg_pkg::IDX_W-1:0]            sample_index_o,
  output logic                                 run_end_o
);
  import lcg_pkg::*;

  logic                      adv;
  logic [1:0]                quad;
  logic [SINE_ADDR_BITS-1:0] addr;
  logic                      amp_neg;
  logic [AMP_ACC_W-1:0]      amp_mag;

  logic                      v1_q, v2_q, v3_q, v4_q;
  logic [SINE_W-1:0]         sine1_q;
  logic [AMP_ACC_W-1:0]      amag1_q;
  logic                      neg1_q, neg2_q, neg3_q;
  logic [COUNT_BITS-1:0]     idx1_q, idx2_q, idx3_q, idx4_q;
  logic                      last1_q, last2_q, last3_q, last4_q;
  logic [PROD1_W-1:0]        prod1_q;
  logic [PROD2_W-1:0]        prod2_q;
  logic [VALUE_W-1:0]        value_q, value_d;

  logic [PROD2_W-1:0]        rounded;
  logic [MAG_W-1:0]          mag;

  assign adv   = !v4_q || !out_stall_i;
  assign pop_o = adv && !empty_i;

  assign quad    = entry_i.phase_top[PHASE_TOP_W-1 -: 2];
  assign addr    = quad[0] ? ~entry_i.phase_top[SINE_ADDR_BITS-1:0]
                           : entry_i.phase_top[SINE_ADDR_BITS-1:0];
  assign amp_neg = entry_i.amp[AMP_ACC_W-1];
  assign amp_mag = amp_neg ? (~entry_i.amp + AMP_ACC_W'(1)) : entry_i.amp;

  assign rounded = prod2_q + (PROD2_W'(1) << (ROUND_SHIFT - 1));
  assign mag     = rounded[PROD2_W-1 -: MAG_W];

  always_comb begin
    if (cfg_i.mute) begin
      value_d = '0;
    end else if (neg3_q) begin
      if (mag > MAG_W'(VALUE_MAX) + MAG_W'(1)) begin
        value_d = {1'b1, {(VALUE_W - 1){1'b0}}};
      end else begin
        value_d = -mag[VALUE_W-1:0];
      end
    end else begin
      if (mag > MAG_W'(VALUE_MAX)) begin
        value_d = VALUE_W'(VALUE_MAX);
      end else begin
        value_d = mag[VALUE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sine1_q <= SINE_TAB[addr];
      amag1_q <= amp_mag;
      neg1_q  <= amp_neg ^ quad[1];
      idx1_q  <= entry_i.cnt;
      last1_q <= entry_i.last;

      prod1_q <= PROD1_W'(amag1_q) * PROD1_W'(sine1_q);
      neg2_q  <= neg1_q;
      idx2_q  <= idx1_q;
      last2_q <= last1_q;

      prod2_q <= PROD2_W'(prod1_q) * PROD2_W'(cfg_i.snr_gain);
      neg3_q  <= neg2_q;
      idx3_q  <= idx2_q;
      last3_q <= last2_q;

      value_q <= value_d;
      idx4_q  <= idx3_q;
      last4_q <= last3_q;
    end
  end

  assign out_valid_o    = v4_q;
  assign sample_value_o = value_q;
  assign sample_index_o = IDX_W'(idx4_q);
  assign run_end_o      = last4_q;

endmodule
